/* design/geaf_pkg.sv */
// Package for the gamepad edge/auto-repeat filter: shared types and constants.
// No dependencies; used by every module of the block.
package geaf_pkg;

  localparam logic [2:0]  CANCEL_POLLS     = 3'd6;
  localparam logic [15:0] CONFIRM_BACK     = 16'h3000;
  localparam logic [15:0] CONFIRM_BIT      = 16'h1000;
  localparam logic [15:0] BACK_BIT         = 16'h2000;
  localparam logic [15:0] DIR_MASK         = 16'h000F;

  localparam logic [14:0] THRESH_RESET     = 15'd16000;
  localparam logic [15:0] DELAY_RESET      = 16'd350;
  localparam logic [15:0] INTERVAL_RESET   = 16'd100;
  localparam logic [15:0] CANCEL_VAL_RESET = 16'h2000;

  localparam logic [1:0] REG_SWAP_CONFIRM   = 2'd0;
  localparam logic [1:0] REG_AXIS_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_INITIAL_DELAY  = 2'd2;
  localparam logic [1:0] REG_REPEAT_INTVL   = 2'd3;

  typedef struct packed {
    logic        swap_confirm;
    logic [14:0] axis_threshold;
    logic [15:0] initial_delay_ms;
    logic [15:0] repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] button_word;
    logic [15:0] stick_x;
    logic [15:0] stick_y;
    logic [31:0] time_ms;
    logic        menu_active;
    logic        menu_opened;
    logic        begin_cancel;
    logic [15:0] cancel_code;
  } poll_t;

  typedef struct packed {
    logic [15:0] buttons_to_game;
    logic        consumed;
    logic [15:0] press_edges;
  } result_t;

endpackage

/* design/geaf_shape.sv */
// Button word shaping: confirm/back swap and stick-to-direction thresholds.
// Depends on geaf_pkg.
module geaf_shape (
  input  logic [15:0] button_word,
  input  logic [15:0] stick_x,
  input  logic [15:0] stick_y,
  input  logic        swap_confirm,
  input  logic [14:0] axis_threshold,
  output logic [15:0] shaped
);
  import geaf_pkg::*;

  logic signed [16:0] x_ext;
  logic signed [16:0] y_ext;
  logic signed [16:0] thr_pos;
  logic signed [16:0] thr_neg;
  logic [15:0]        swapped;

  assign x_ext   = $signed({stick_x[15], stick_x});
  assign y_ext   = $signed({stick_y[15], stick_y});
  assign thr_pos = $signed({2'b00, axis_threshold});
  assign thr_neg = -thr_pos;

  always_comb begin
    swapped = button_word;
    if (swap_confirm) begin
      swapped = (button_word & ~CONFIRM_BACK)
              | ((button_word & CONFIRM_BIT) << 1)
              | ((button_word & BACK_BIT) >> 1);
    end
    shaped = swapped;
    if (x_ext < thr_neg) shaped[2] = 1'b1;
    if (x_ext > thr_pos) shaped[3] = 1'b1;
    if (y_ext < thr_neg) shaped[1] = 1'b1;
    if (y_ext > thr_pos) shaped[0] = 1'b1;
  end

endmodule

/* design/geaf_core.sv */
// Per-poll state: cancel injection, wait-for-release, edges and auto-repeat.
// Depends on geaf_pkg and geaf_shape.
module geaf_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  geaf_pkg::cfg_t   cfg,
  input  geaf_pkg::poll_t  poll,
  output geaf_pkg::result_t result
);
  import geaf_pkg::*;

  logic [15:0] previous_buttons;
  logic [31:0] repeat_deadline;
  logic        wait_release;
  logic [2:0]  cancel_left;
  logic [15:0] cancel_value;

  logic [15:0] previous_buttons_next;
  logic [31:0] repeat_deadline_next;
  logic        wait_release_next;
  logic [2:0]  cancel_left_next;
  logic [15:0] cancel_value_next;

  logic [2:0]  cl;
  logic [15:0] cv;
  logic        wr;
  logic [15:0] shaped;
  logic [31:0] since;

  geaf_shape u_shape (
    .button_word    (poll.button_word),
    .stick_x        (poll.stick_x),
    .stick_y        (poll.stick_y),
    .swap_confirm   (cfg.swap_confirm),
    .axis_threshold (cfg.axis_threshold),
    .shaped         (shaped)
  );

  assign cl    = poll.begin_cancel ? CANCEL_POLLS : cancel_left;
  assign cv    = poll.begin_cancel ? poll.cancel_code : cancel_value;
  assign wr    = poll.menu_opened | wait_release;
  assign since = poll.time_ms - repeat_deadline;

  always_comb begin
    previous_buttons_next = previous_buttons;
    repeat_deadline_next  = repeat_deadline;
    wait_release_next     = wr;
    cancel_left_next      = cl;
    cancel_value_next     = cv;
    result                = '0;
    if (cl != 3'd0) begin
      cancel_left_next       = cl - 3'd1;
      result.buttons_to_game = cv;
    end else if (!poll.menu_active) begin
      result.buttons_to_game = poll.button_word;
    end else begin
      result.consumed       = 1'b1;
      previous_buttons_next = shaped;
      if (wr) begin
        wait_release_next = (shaped != 16'd0);
      end else begin
        result.press_edges = shaped & ~previous_buttons;
        if (shaped != previous_buttons) begin
          repeat_deadline_next = poll.time_ms + {16'd0, cfg.initial_delay_ms};
        end else if (!since[31]) begin
          result.press_edges   = result.press_edges | (shaped & DIR_MASK);
          repeat_deadline_next = poll.time_ms + {16'd0, cfg.repeat_interval_ms};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_buttons <= '0;
      repeat_deadline  <= '0;
      wait_release     <= 1'b1;
      cancel_left      <= '0;
      cancel_value     <= CANCEL_VAL_RESET;
    end else if (step) begin
      previous_buttons <= previous_buttons_next;
      repeat_deadline  <= repeat_deadline_next;
      wait_release     <= wait_release_next;
      cancel_left      <= cancel_left_next;
      cancel_value     <= cancel_value_next;
    end
  end

  a_cancel_bound: assert property (@(posedge clk) disable iff (rst)
    cancel_left <= CANCEL_POLLS)
    else $error("cancel count above limit");

  a_edges_only_consumed: assert property (@(posedge clk) disable iff (rst)
    step && !result.consumed |-> result.press_edges == 16'd0)
    else $error("edges on a poll not consumed");

  a_cancel_countdown: assert property (@(posedge clk) disable iff (rst)
    step && !poll.begin_cancel && cancel_left != 3'd0 |=>
      cancel_left == $past(cancel_left) - 3'd1)
    else $error("cancel countdown slipped");

  a_wait_no_edges: assert property (@(posedge clk) disable iff (rst)
    step && wr |-> result.press_edges == 16'd0)
    else $error("edges while waiting for release");

endmodule

/* design/gamepad_edge_autorepeat_filter_core.sv */
// Top level of the gamepad edge/auto-repeat filter: ports, config registers,
// input and result registers. Depends on geaf_pkg and geaf_core.
//
//   channel  dir  handshake          payload
//   s        in   s_tvalid/s_tready  s_tdata, s_tuser
//   m        out  m_tvalid/m_tready  m_tdata, m_tuser
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// One poll per cycle sustained while m is not stalled.
// The poll is processed between the input register and the result register;
// the filter state updates in that same cycle.
// A stalled m holds the result and the input register; s_tready drops once both are full.
// rst resets filter state, config and valid flags, but not the poll and result data.
module gamepad_edge_autorepeat_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // button_word[15:0], stick_x[31:16], stick_y[47:32], time_ms[79:48], cancel_code[95:80]
  input  logic [95:0] s_tdata,
  // menu_active[0], menu_opened[1], begin_cancel[2]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // buttons_to_game[15:0], press_edges[31:16]
  output logic [31:0] m_tdata,
  // consumed[0]
  output logic [0:0]  m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import geaf_pkg::*;

  cfg_t    cfg;
  poll_t   poll;
  logic    in_valid;
  logic    advance;
  result_t core_result;
  result_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_confirm       <= 1'b0;
      cfg.axis_threshold     <= THRESH_RESET;
      cfg.initial_delay_ms   <= DELAY_RESET;
      cfg.repeat_interval_ms <= INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWAP_CONFIRM:   cfg.swap_confirm       <= cfg_data[0];
        REG_AXIS_THRESHOLD: cfg.axis_threshold     <= cfg_data[14:0];
        REG_INITIAL_DELAY:  cfg.initial_delay_ms   <= cfg_data;
        REG_REPEAT_INTVL:   cfg.repeat_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      poll.button_word  <= s_tdata[15:0];
      poll.stick_x      <= s_tdata[31:16];
      poll.stick_y      <= s_tdata[47:32];
      poll.time_ms      <= s_tdata[79:48];
      poll.cancel_code  <= s_tdata[95:80];
      poll.menu_active  <= s_tuser[0];
      poll.menu_opened  <= s_tuser[1];
      poll.begin_cancel <= s_tuser[2];
    end
  end

  geaf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .poll   (poll),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_result;
    end
  end

  assign m_tdata = {res.press_edges, res.buttons_to_game};
  assign m_tuser = res.consumed;

endmodule

/* verif/gamepad_edge_autorepeat_filter_core_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for gamepad_edge_autorepeat_filter_core: directed and random polls,
// scoreboard against a behavioral filter model. Depends on geaf_pkg and the core RTL.
module gamepad_edge_autorepeat_filter_core_test;
  import geaf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_SWAP_CONFIRM;
  logic [15:0] cfg_data = '0;

  gamepad_edge_autorepeat_filter_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cfg_t        filter_cfg;
  logic [15:0] last_word;
  logic [31:0] repeat_due;
  logic        awaiting_release;
  logic [2:0]  cancel_left;
  logic [15:0] cancel_word;

  poll_t   pending_polls[$];
  result_t results_due[$];
  poll_t   next_poll;
  poll_t   seen_poll;
  result_t want_result;
  result_t got_result;
  logic [31:0] poll_clock;
  bit      s_fire = 1'b0;
  bit      hold_start = 1'b0;
  int      hold_left = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      failures = 0;
  int      cycle_count = 0;
  int      in_flight = 0;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic result_t filter_poll(input poll_t p);
    result_t     r;
    logic [15:0] word;
    logic [31:0] lag;
    int          x;
    int          y;
    int          thr;
    r = '0;
    if (p.begin_cancel) begin
      cancel_left = CANCEL_POLLS;
      cancel_word = p.cancel_code;
    end
    if (p.menu_opened) awaiting_release = 1'b1;
    if (cancel_left != 0) begin
      cancel_left = cancel_left - 3'd1;
      r.buttons_to_game = cancel_word;
    end else if (!p.menu_active) begin
      r.buttons_to_game = p.button_word;
    end else begin
      word = p.button_word;
      if (filter_cfg.swap_confirm)
        word = (word & ~CONFIRM_BACK) | ((word & CONFIRM_BIT) << 1) | ((word & BACK_BIT) >> 1);
      x = int'($signed(p.stick_x));
      y = int'($signed(p.stick_y));
      thr = int'(filter_cfg.axis_threshold);
      if (x < -thr) word |= 16'h0004;
      if (x > thr) word |= 16'h0008;
      if (y < -thr) word |= 16'h0002;
      if (y > thr) word |= 16'h0001;
      r.consumed = 1'b1;
      if (awaiting_release) begin
        last_word = word;
        if (word == 16'h0000) awaiting_release = 1'b0;
      end else begin
        r.press_edges = word & ~last_word;
        if (word != last_word) begin
          repeat_due = p.time_ms + {16'd0, filter_cfg.initial_delay_ms};
        end else begin
          lag = p.time_ms - repeat_due;
          if (!lag[31]) begin
            r.press_edges |= word & DIR_MASK;
            repeat_due = p.time_ms + {16'd0, filter_cfg.repeat_interval_ms};
          end
        end
        last_word = word;
      end
    end
    return r;
  endfunction

  function automatic poll_t make_poll(input logic [15:0] buttons, input logic [15:0] x,
                                      input logic [15:0] y, input logic [31:0] t,
                                      input bit active, input bit opened, input bit cancel,
                                      input logic [15:0] code);
    poll_t p;
    p.button_word = buttons;
    p.stick_x = x;
    p.stick_y = y;
    p.time_ms = t;
    p.menu_active = active;
    p.menu_opened = opened;
    p.begin_cancel = cancel;
    p.cancel_code = code;
    return p;
  endfunction

  task automatic enqueue_poll(input poll_t p);
    pending_polls.insert(pending_polls.size(), p);
  endtask

  function automatic logic [15:0] pick_axis(input bit deflect);
    int thr;
    int v;
    thr = int'(filter_cfg.axis_threshold);
    if (deflect) begin
      if ($urandom_range(1) == 0 || thr == 32767) v = -$urandom_range(32768, thr + 1);
      else v = $urandom_range(32767, thr + 1);
    end else if ($urandom_range(9) == 0) begin
      v = $urandom_range(1) ? thr : -thr;
    end else begin
      v = $urandom_range(2 * thr) - thr;
    end
    return v[15:0];
  endfunction

  function automatic logic [31:0] advance_clock();
    int r;
    r = $urandom_range(99);
    if (r < 60) poll_clock += $urandom_range(150);
    else if (r < 85) poll_clock += $urandom_range(1000);
    else if (r < 97) poll_clock += $urandom_range(70000);
    else poll_clock = $urandom;
    return poll_clock;
  endfunction

  function automatic logic [15:0] pick_pattern();
    case ($urandom_range(3))
      0: return 16'($urandom_range(15));
      1: return 16'($urandom_range(15)) | 16'($urandom_range(3) << 12);
      2: return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly held runs with random content so repeats fire; the rest is raw noise.
  task automatic queue_random_polls(input int count);
    int          left;
    int          run;
    logic [15:0] pattern;
    bit          dx;
    bit          dy;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 10) begin
        enqueue_poll(make_poll(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), 16'($urandom)));
        left--;
      end else begin
        run = $urandom_range(1, 12);
        pattern = pick_pattern();
        dx = ($urandom_range(9) < 3);
        dy = ($urandom_range(9) < 3);
        for (int i = 0; i < run; i++) begin
          enqueue_poll(make_poll(pattern, pick_axis(dx), pick_axis(dy),
                                 advance_clock(), $urandom_range(9) != 0,
                                 $urandom_range(29) == 0, $urandom_range(33) == 0,
                                 16'($urandom)));
          left--;
        end
        if ($urandom_range(1)) begin
          enqueue_poll(make_poll(16'h0000, pick_axis(1'b0), pick_axis(1'b0),
                                 advance_clock(), 1'b1, 1'b0, 1'b0, 16'($urandom)));
          left--;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_SWAP_CONFIRM:   filter_cfg.swap_confirm = value[0];
      REG_AXIS_THRESHOLD: filter_cfg.axis_threshold = value[14:0];
      REG_INITIAL_DELAY:  filter_cfg.initial_delay_ms = value;
      REG_REPEAT_INTVL:   filter_cfg.repeat_interval_ms = value;
      default: ;
    endcase
  endtask

  task automatic set_filter(input bit swap, input logic [14:0] thr, input logic [15:0] delay,
                            input logic [15:0] intvl);
    write_reg(REG_SWAP_CONFIRM, {15'd0, swap});
    write_reg(REG_AXIS_THRESHOLD, {1'b0, thr});
    write_reg(REG_INITIAL_DELAY, delay);
    write_reg(REG_REPEAT_INTVL, intvl);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_polls.size() != 0 || in_flight != 0 || results_due.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic report_mismatch(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
    failures++;
    $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_fire) begin
      if (pending_polls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_poll = pending_polls.pop_front();
        in_flight++;
        s_tvalid <= 1'b1;
        s_tdata <= {next_poll.cancel_code, next_poll.time_ms, next_poll.stick_y,
                    next_poll.stick_x, next_poll.button_word};
        s_tuser <= {next_poll.begin_cancel, next_poll.menu_opened, next_poll.menu_active};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gamepad_edge_autorepeat_filter_core regression: fail");
      $finish;
    end else if (rst) begin
      s_fire = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        seen_poll.button_word = s_tdata[15:0];
        seen_poll.stick_x = s_tdata[31:16];
        seen_poll.stick_y = s_tdata[47:32];
        seen_poll.time_ms = s_tdata[79:48];
        seen_poll.cancel_code = s_tdata[95:80];
        seen_poll.menu_active = s_tuser[0];
        seen_poll.menu_opened = s_tuser[1];
        seen_poll.begin_cancel = s_tuser[2];
        results_due.insert(results_due.size(), filter_poll(seen_poll));
      end
      if (m_tvalid && m_tready) begin
        got_result.buttons_to_game = m_tdata[15:0];
        got_result.press_edges = m_tdata[31:16];
        got_result.consumed = m_tuser[0];
        if (results_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected transaction: expected none, actual %h", $time, got_result);
        end else begin
          want_result = results_due.pop_front();
          in_flight--;
          if (got_result.buttons_to_game !== want_result.buttons_to_game)
            report_mismatch("buttons_to_game", want_result.buttons_to_game,
                            got_result.buttons_to_game);
          if (got_result.consumed !== want_result.consumed)
            report_mismatch("consumed", 16'(want_result.consumed), 16'(got_result.consumed));
          if (got_result.press_edges !== want_result.press_edges)
            report_mismatch("press_edges", want_result.press_edges, got_result.press_edges);
        end
      end
      s_fire = s_tvalid && s_tready;
    end
  end

  initial begin
    filter_cfg = {1'b0, THRESH_RESET, DELAY_RESET, INTERVAL_RESET};
    last_word = '0;
    repeat_due = '0;
    awaiting_release = 1'b1;
    cancel_left = '0;
    cancel_word = CANCEL_VAL_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: release wait, edges, repeat timing, stick limits, bypass, deadline wrap, cancel
    enqueue_poll(make_poll(16'h0001, 16'd0, 16'd0, 32'd0, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0000, 16'd0, 16'd0, 32'd10, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0001, 16'd0, 16'd0, 32'd20, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0001, 16'd0, 16'd0, 32'd200, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0001, 16'd0, 16'd0, 32'd370, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0001, 16'd0, 16'd0, 32'd469, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0001, 16'd0, 16'd0, 32'd470, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h3001, 16'd0, 16'd0, 32'd500, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h3001, 16'h8000, 16'd0, 32'd510, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h3001, 16'd16000, -16'sd16000, 32'd520, 1'b1, 1'b0, 1'b0,
                           16'h0));
    enqueue_poll(make_poll(16'h3001, 16'd16001, 16'h7FFF, 32'd530, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0000, 16'd0, -16'sd16001, 32'd540, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'hFFFF, 16'h7FFF, 16'h8000, 32'd550, 1'b0, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'hFFFF, 16'd0, 16'd0, 32'd560, 1'b1, 1'b1, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0000, 16'd0, 16'd0, 32'd570, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0002, 16'd0, 16'd0, 32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0002, 16'd0, 16'd0, 32'h0000_0010, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0002, 16'd0, 16'd0, 32'h0000_005E, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0004, 16'd0, 16'd0, 32'h60, 1'b1, 1'b1, 1'b1, 16'hFFFF));
    for (int i = 0; i < 5; i++)
      enqueue_poll(make_poll(16'($urandom), 16'd0, 16'd0, 32'h70 + i, 1'(i % 2), 1'b0, 1'b0,
                             16'h0));
    enqueue_poll(make_poll(16'h0000, 16'd0, 16'd0, 32'h100, 1'b1, 1'b0, 1'b0, 16'h0));
    enqueue_poll(make_poll(16'h0004, 16'd0, 16'd0, 32'h110, 1'b1, 1'b0, 1'b0, 16'h0));
    drain();

    set_filter(1'b1, 15'd0, 16'd0, 16'd0);
    poll_clock = 32'hFFFF_F000 - $urandom_range(5000);
    queue_random_polls(300);
    drain();

    set_filter(1'b0, 15'd32767, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 75;
    queue_random_polls(300);
    drain();

    set_filter(1'b1, 15'd16000, 16'd350, 16'd100);
    send_idle_pct = 0;
    stall_pct = 75;
    queue_random_polls(300);
    drain();

    set_filter(1'($urandom_range(1)), 15'($urandom_range(32767)), 16'($urandom_range(600)),
               16'($urandom_range(200)));
    send_idle_pct = 8;
    stall_pct = 8;
    queue_random_polls(400);
    drain();

    // receiver holds off while the sender keeps offering
    set_filter(1'b0, 15'($urandom_range(20000)), 16'($urandom_range(300)),
               16'($urandom_range(80)));
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk);
    hold_start = 1'b1;
    queue_random_polls(300);
    drain();

    set_filter(1'($urandom_range(1)), 15'($urandom_range(32767)), 16'($urandom_range(400)),
               16'($urandom_range(150)));
    queue_random_polls(350);
    drain();

    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("gamepad_edge_autorepeat_filter_core regression: pass");
    end else begin
      $display("gamepad_edge_autorepeat_filter_core regression: fail");
    end
    $finish;
  end

endmodule
